[rtl/core/u8d_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

  // Widths of the decoded fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 26;
  localparam int unsigned LenW   = 3;
  localparam int unsigned LeadPW = 7;
  localparam int unsigned ContW  = 6;

  // Sequence lengths announced by the lead byte.
  localparam logic [LenW-1:0] SeqLen1 = 3'd1;
  localparam logic [LenW-1:0] SeqLen2 = 3'd2;
  localparam logic [LenW-1:0] SeqLen3 = 3'd3;
  localparam logic [LenW-1:0] SeqLen4 = 3'd4;
  localparam logic [LenW-1:0] SeqLen5 = 3'd5;

  // Payload masks of the lead byte for each sequence length.
  localparam logic [ByteW-1:0] LeadMask1 = 8'h7F;
  localparam logic [ByteW-1:0] LeadMask2 = 8'h1F;
  localparam logic [ByteW-1:0] LeadMask3 = 8'h0F;
  localparam logic [ByteW-1:0] LeadMask4 = 8'h07;
  localparam logic [ByteW-1:0] LeadMask5 = 8'h03;

  // Result of decoding one lead byte.
  typedef struct packed {
    logic [LenW-1:0]   len;
    logic [LeadPW-1:0] payload;
  } lead_t;

endpackage

[rtl/core/u8d_lead_decode.sv]
// Lead-byte decoder: sequence length and payload bits of a UTF-8 lead byte.
module u8d_lead_decode
  import u8d_pkg::*;
(
  input  logic [ByteW-1:0] lead_byte_i,
  output lead_t            lead_o
);

  logic [ByteW-1:0] masked;

  // Classify the byte by its top bits; anything else opens a 5-byte sequence.
  always_comb begin
    unique casez (lead_byte_i)
      8'b0???????: begin
        lead_o.len = SeqLen1;
        masked     = lead_byte_i & LeadMask1;
      end
      8'b110?????: begin
        lead_o.len = SeqLen2;
        masked     = lead_byte_i & LeadMask2;
      end
      8'b1110????: begin
        lead_o.len = SeqLen3;
        masked     = lead_byte_i & LeadMask3;
      end
      8'b11110???: begin
        lead_o.len = SeqLen4;
        masked     = lead_byte_i & LeadMask4;
      end
      default: begin
        lead_o.len = SeqLen5;
        masked     = lead_byte_i & LeadMask5;
      end
    endcase
    lead_o.payload = masked[LeadPW-1:0];
  end

endmodule

[rtl/core/utf8_stream_decoder.sv]
// UTF-8 stream decoder: one byte per beat in, one code point per completed or truncated sequence out.
// A code point passes through the input register and then the output register on its way out.
// Throughput: one byte per cycle while the output is not stalled, set by the single accumulator update per input beat.
// A waiting result stalls input only once the input register also holds a byte.
// Reset (rst_ni low, asynchronous) empties both stages and clears the sequence state.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: tdata = data_byte[7:0]; tlast = end_of_string.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  // Output stream: tlast = last_char; tuser = truncated.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [25:0] code_point, [28:26] seq_length, [31:29] zero
  output logic        m_axis_tuser,   // [0] truncated
  output logic        m_axis_tlast
);

  // Input register.
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_eos_q;

  // Sequence state.
  logic [LenW-1:0] rem_q, rem_d;
  logic [CpW-1:0]  acc_q, acc_d;
  logic [LenW-1:0] cur_len_q, cur_len_d;

  // Output register.
  logic            out_vld_q;
  logic [CpW-1:0]  out_cp_q, res_cp;
  logic [LenW-1:0] out_len_q, res_len;
  logic            out_trunc_q, res_trunc;
  logic            out_last_q, res_last;
  logic            res_vld;

  logic  out_free;
  logic  advance;
  lead_t lead;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  u8d_lead_decode u_lead (
    .lead_byte_i (in_byte_q),
    .lead_o      (lead)
  );

  // Sequence step: open a sequence on a lead byte or shift in a continuation byte.
  always_comb begin
    rem_d     = rem_q;
    acc_d     = acc_q;
    cur_len_d = cur_len_q;
    res_vld   = 1'b0;
    res_cp    = acc_q;
    res_len   = cur_len_q;
    res_trunc = 1'b0;
    res_last  = in_eos_q;
    if (rem_q == '0) begin
      acc_d     = {{(CpW-LeadPW){1'b0}}, lead.payload};
      cur_len_d = lead.len;
      rem_d     = lead.len - 3'd1;
      res_cp    = acc_d;
      res_len   = lead.len;
      if (lead.len == SeqLen1) begin
        res_vld = 1'b1;
      end else if (in_eos_q) begin
        res_vld   = 1'b1;
        res_trunc = 1'b1;
      end
    end else begin
      acc_d  = {acc_q[CpW-ContW-1:0], in_byte_q[ContW-1:0]};
      rem_d  = rem_q - 3'd1;
      res_cp = acc_d;
      if (rem_d == '0) begin
        res_vld = 1'b1;
      end else if (in_eos_q) begin
        res_vld   = 1'b1;
        res_trunc = 1'b1;
      end
    end
    // Any emitted result closes the sequence.
    if (res_vld) begin
      rem_d     = '0;
      acc_d     = '0;
      cur_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      acc_q     <= '0;
      cur_len_q <= '0;
    end else if (advance) begin
      rem_q     <= rem_d;
      acc_q     <= acc_d;
      cur_len_q <= cur_len_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_cp_q    <= res_cp;
      out_len_q   <= res_len;
      out_trunc_q <= res_trunc;
      out_last_q  <= res_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_len_q, out_cp_q};
  assign m_axis_tuser  = out_trunc_q;
  assign m_axis_tlast  = out_last_q;

  // An open sequence always expects fewer bytes than its announced length.
  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> (rem_q < cur_len_q && cur_len_q >= SeqLen2 && cur_len_q <= SeqLen5))
    else $error("remaining count out of step with sequence length");

  // A truncated result only comes at the end of a string.
  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("truncated result without end of string");

  // Every result carries a legal length.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_len_q >= SeqLen1 && out_len_q <= SeqLen5))
    else $error("result length out of range");

  // A complete (not truncated) result of length one carries at most seven bits.
  a_ascii_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_len_q == SeqLen1) |-> (out_cp_q[CpW-1:LeadPW] == '0))
    else $error("single-byte result wider than seven bits");

endmodule
